// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the uv mapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/stuv_pkg.sv -----
// ---------------------------------------------------------------------------
// stuv_pkg
// shared constants and angle table for the sphere uv mapper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stuv_pkg;

    localparam int COORD_W       = 16;
    localparam int TEX_FRAC_BITS = 16;
    localparam int OUT_W         = TEX_FRAC_BITS + 1;
    // scaled vector components fit 34 bits signed; grow by cordic gain
    localparam int VEC_W   = 40;
    localparam int ANG_W   = 36;
    localparam int SQ_W    = 64;
    localparam int RT_W    = 32;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(64'sh80000000);
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sh40000000);

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    typedef struct packed {
        vec_t re;
        vec_t im;
        ang_t acc;
        logic axis;
    } cord_t;

    function automatic ang_t angle_of(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            24: a = 32'h00000029;
            25: a = 32'h00000014;
            26: a = 32'h0000000A;
            27: a = 32'h00000005;
            28: a = 32'h00000003;
            29: a = 32'h00000001;
            30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return ANG_W'(a);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stuv_cordic.sv -----
// ---------------------------------------------------------------------------
// stuv_cordic
// pipelined cordic vectoring, one stage per register, angle in 2^-32 turn
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stuv_cordic
    import stuv_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  wire logic clk,
    input  wire logic en,
    input  wire vec_t re,
    input  wire vec_t im,
    output ang_t      angle
);

    cord_t pre_reg;
    cord_t pre_next;
    cord_t stg_reg [STAGES];

    // quadrant pre-rotation and axis detection
    always_comb
    begin
        pre_next.re   = re;
        pre_next.im   = im;
        pre_next.acc  = '0;
        pre_next.axis = 1'b0;
        if (im == '0)
        begin
            pre_next.axis = 1'b1;
            pre_next.acc  = re < 0 ? HALF_TURN : '0;
        end
        else if (re < 0)
        begin
            if (im > 0)
            begin
                pre_next.re  = im;
                pre_next.im  = -re;
                pre_next.acc = QUARTER_TURN;
            end
            else
            begin
                pre_next.re  = -im;
                pre_next.im  = re;
                pre_next.acc = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        cord_t src;
        cord_t stg_next;
        if (i == 0)
        begin : g_first
            assign src = pre_reg;
        end
        else
        begin : g_rest
            assign src = stg_reg[i-1];
        end

        always_comb
        begin
            stg_next = src;
            if (!src.axis)
            begin
                if (src.im >= 0)
                begin
                    stg_next.re  = src.re + (src.im >>> i);
                    stg_next.im  = src.im - (src.re >>> i);
                    stg_next.acc = src.acc + angle_of(i);
                end
                else
                begin
                    stg_next.re  = src.re - (src.im >>> i);
                    stg_next.im  = src.im + (src.re >>> i);
                    stg_next.acc = src.acc - angle_of(i);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[i] <= stg_next;
            end
        end
    end

    assign angle = stg_reg[STAGES-1].acc;

endmodule

`default_nettype wire

// ----- hw/rtl/stuv_isqrt.sv -----
// ---------------------------------------------------------------------------
// stuv_isqrt
// pipelined floor square root, one result bit per stage, with delay of y
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stuv_isqrt
    import stuv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   sq,
    input  wire vec_t              y_in,
    output logic [RT_W-1:0]        root,
    output vec_t                   y_out
);

    logic [SQ_W-1:0] rem_reg  [RT_W+1];
    logic [RT_W-1:0] res_reg  [RT_W+1];
    vec_t            y_reg    [RT_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= sq;
            res_reg[0] <= '0;
            y_reg[0]   <= y_in;
        end
    end

    // trial-squaring square root, bit k from the top per stage
    for (genvar k = 0; k < RT_W; k++)
    begin : g_bit
        localparam int B = RT_W - 1 - k;
        logic [SQ_W-1:0] trial;
        logic [RT_W-1:0] cand;
        assign cand  = res_reg[k] | (RT_W'(1) << B);
        assign trial = SQ_W'(cand) * SQ_W'(cand);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y_reg[k+1]   <= y_reg[k];
                rem_reg[k+1] <= rem_reg[k];
                res_reg[k+1] <= (trial <= rem_reg[k]) ? cand : res_reg[k];
            end
        end
    end

    assign root  = res_reg[RT_W];
    assign y_out = y_reg[RT_W];

endmodule

`default_nettype wire

// ----- hw/rtl/stuv_vertex.sv -----
// ---------------------------------------------------------------------------
// stuv_vertex
// one vertex: azimuth and polar cordic plus square root, quantized s and t
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stuv_vertex
    import stuv_pkg::*;
#(
    parameter int STAGES   = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic signed [COORD_W-1:0]  x,
    input  wire logic signed [COORD_W-1:0]  y,
    input  wire logic signed [COORD_W-1:0]  z,
    output logic [OUT_W-1:0]                s,
    output logic [OUT_W-1:0]                t
);

    // extra depth of the polar path ahead of its cordic: sq reg plus root regs
    localparam int LAT_SQ = RT_W + 2;

    logic signed [2*COORD_W-1:0] x_sq;
    logic signed [2*COORD_W-1:0] z_sq;
    logic [SQ_W-1:0] sq_reg;
    vec_t            y_reg;
    logic [RT_W-1:0] root;
    vec_t            y_dly;
    ang_t            az;
    ang_t            pol;
    ang_t            az_dly [LAT_SQ];
    logic [SQ_W-1:0] az_c;
    logic [SQ_W-1:0] pol_c;

    assign x_sq = x * x;
    assign z_sq = z * z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= (SQ_W'(x_sq) + SQ_W'(z_sq)) << 30;
            y_reg  <= VEC_W'(y) <<< 15;
        end
    end

    stuv_cordic #(.STAGES(STAGES)) u_az (
        .clk   (clk),
        .en    (en),
        .re    (VEC_W'(z) <<< 15),
        .im    (VEC_W'(x) <<< 15),
        .angle (az)
    );

    stuv_isqrt u_sqrt (
        .clk   (clk),
        .en    (en),
        .sq    (sq_reg),
        .y_in  (y_reg),
        .root  (root),
        .y_out (y_dly)
    );

    stuv_cordic #(.STAGES(STAGES)) u_pol (
        .clk   (clk),
        .en    (en),
        .re    (y_dly),
        .im    (VEC_W'(root)),
        .angle (pol)
    );

    // align azimuth with the longer polar path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_dly[0] <= az;
            for (int i = 1; i < LAT_SQ; i++)
            begin
                az_dly[i] <= az_dly[i-1];
            end
        end
    end

    always_comb
    begin
        az_c = SQ_W'(az_dly[LAT_SQ-1]);
        if (az_dly[LAT_SQ-1] < -HALF_TURN)
        begin
            az_c = SQ_W'(-HALF_TURN);
        end
        if (az_dly[LAT_SQ-1] > HALF_TURN)
        begin
            az_c = SQ_W'(HALF_TURN);
        end
        pol_c = SQ_W'(pol);
        if (pol < 0)
        begin
            pol_c = '0;
        end
        if (pol > HALF_TURN)
        begin
            pol_c = SQ_W'(HALF_TURN);
        end
    end

    logic [SQ_W-1:0] s_full;
    logic [SQ_W-1:0] t_full;
    assign s_full = (az_c + SQ_W'(HALF_TURN) + (SQ_W'(1) << (31 - TEX_FRAC_BITS)))
                    >> (32 - TEX_FRAC_BITS);
    assign t_full = (pol_c + (SQ_W'(1) << (30 - TEX_FRAC_BITS))) >> (31 - TEX_FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s <= OUT_W'(s_full);
            t <= OUT_W'(t_full);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sphere_triangle_uv_mapper_core.sv -----
// ---------------------------------------------------------------------------
// sphere_triangle_uv_mapper_core
// spherical texture coordinates with seam fix for one triangle per transfer
// ---------------------------------------------------------------------------
// Takes one triangle per clock unless the pipe is held and gives one result
// per triangle. From the input transfer to the result it passes through the
// squaring register, the square root input register and its 32 bit stages,
// the pre-rotation and CORDIC_STAGES stages of the polar cordic, the quantize
// register and the seam fix register. The azimuth cordic runs beside the
// square root and is delayed to match. The whole pipe advances unless a valid
// result is held by out_stall; then every stage holds and in_stall is raised
// in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sphere_triangle_uv_mapper_core
    import stuv_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [COORD_W-1:0]  v0_x,
    input  wire logic signed [COORD_W-1:0]  v0_y,
    input  wire logic signed [COORD_W-1:0]  v0_z,
    input  wire logic signed [COORD_W-1:0]  v1_x,
    input  wire logic signed [COORD_W-1:0]  v1_y,
    input  wire logic signed [COORD_W-1:0]  v1_z,
    input  wire logic signed [COORD_W-1:0]  v2_x,
    input  wire logic signed [COORD_W-1:0]  v2_y,
    input  wire logic signed [COORD_W-1:0]  v2_z,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [OUT_W-1:0]                s0,
    output logic [OUT_W-1:0]                s1,
    output logic [OUT_W-1:0]                s2,
    output logic [OUT_W-1:0]                t0,
    output logic [OUT_W-1:0]                t1,
    output logic [OUT_W-1:0]                t2
);

    // vertex latency: sq reg, RT_W+1 root regs, pre reg, stages, quant reg
    localparam int LAT = RT_W + CORDIC_STAGES + 4;
    localparam int TEX_ONE  = 1 << TEX_FRAC_BITS;
    localparam int TEX_HALF = 1 << (TEX_FRAC_BITS - 1);

    logic            en;
    logic [LAT:0]    vld_reg;
    logic [OUT_W-1:0] sv [3];
    logic [OUT_W-1:0] tv [3];
    logic signed [COORD_W-1:0] vx [3];
    logic signed [COORD_W-1:0] vy [3];
    logic signed [COORD_W-1:0] vz [3];

    // output holds while stalled with a result waiting
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign vx[0] = v0_x;
    assign vy[0] = v0_y;
    assign vz[0] = v0_z;
    assign vx[1] = v1_x;
    assign vy[1] = v1_y;
    assign vz[1] = v1_z;
    assign vx[2] = v2_x;
    assign vy[2] = v2_y;
    assign vz[2] = v2_z;

    for (genvar k = 0; k < 3; k++)
    begin : g_vert
        stuv_vertex #(.STAGES(CORDIC_STAGES)) u_vert (
            .clk (clk),
            .en  (en),
            .x   (vx[k]),
            .y   (vy[k]),
            .z   (vz[k]),
            .s   (sv[k]),
            .t   (tv[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-1:0], in_valid};
        end
    end

    // seam fix-up on the quantized s coordinates
    logic [OUT_W:0] a0;
    logic [OUT_W:0] a1;
    logic [OUT_W:0] a2;
    always_comb
    begin
        a0 = (OUT_W+1)'(sv[0]);
        a1 = (OUT_W+1)'(sv[1]);
        a2 = (OUT_W+1)'(sv[2]);
        if (a1 == (OUT_W+1)'(TEX_ONE))
        begin
            a1 = '0;
        end
        if (a1 + (OUT_W+1)'(TEX_HALF) <= a0)
        begin
            a1 = a1 + (OUT_W+1)'(TEX_ONE);
        end
        if (a2 + (OUT_W+1)'(TEX_HALF) <= a0)
        begin
            a2 = a2 + (OUT_W+1)'(TEX_ONE);
        end
        if (a2 == (OUT_W+1)'(TEX_ONE))
        begin
            if (a0 < (OUT_W+1)'(TEX_HALF))
            begin
                a0 = a0 + (OUT_W+1)'(TEX_ONE);
            end
            if (a1 < (OUT_W+1)'(TEX_HALF))
            begin
                a1 = a1 + (OUT_W+1)'(TEX_ONE);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0 <= OUT_W'(a0);
            s1 <= OUT_W'(a1);
            s2 <= OUT_W'(a2);
            t0 <= tv[0];
            t1 <= tv[1];
            t2 <= tv[2];
        end
    end

    assign out_valid = vld_reg[LAT];

    `CHK_IMPL(a_stall_only_on_hold, clk, rst_n, in_stall, out_valid && out_stall, "bad stall")
    `CHK_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid, "held dropped")
    `CHK_NEXT(a_hold_s0, clk, rst_n, out_valid && out_stall, $stable(s0) && $stable(t2), "moved")

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// drives triangles into the uv mapper and checks every result against an
// in-bench fixed-point model of the azimuth/polar cordic and the seam fix-up
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
    logic [16:0] s0, s1, s2, t0, t1, t2;
} uv_result_t;

class uv_scoreboard;
    uv_result_t pending[$];
    int mismatches = 0;

    static function longint shr_signed(longint v, int sh);
        return v >>> sh;
    endfunction

    static function longint turn_step(int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            default: a = 32'h0;
        endcase
        return longint'(a);
    endfunction

    static function longint floor_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
        begin
            bitv >>= 2;
        end
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // angle in 2^-32 turn
    static function longint vector_turns(longint re, longint im);
        longint acc, tmp, dr, di;
        acc = 0;
        if (im == 0)
        begin
            return (re < 0) ? 64'sd2147483648 : 0;
        end
        if (re < 0)
        begin
            if (im > 0)
            begin
                tmp = im; im = -re; re = tmp; acc = 64'sd1073741824;
            end
            else
            begin
                tmp = -im; im = re; re = tmp; acc = -64'sd1073741824;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dr = shr_signed(im, i);
            di = shr_signed(re, i);
            if (im >= 0)
            begin
                re += dr; im -= di; acc += turn_step(i);
            end
            else
            begin
                re -= dr; im += di; acc -= turn_step(i);
            end
        end
        return acc;
    endfunction

    static function void vertex_uv(logic signed [15:0] x, logic signed [15:0] y,
                                   logic signed [15:0] z, output longint s,
                                   output longint t);
        longint a, p, r, xl, yl, zl;
        longint unsigned sq;
        xl = x; yl = y; zl = z;
        sq = longint'(xl * xl + zl * zl) << 30;
        a = vector_turns(zl * 32768, xl * 32768);
        if (a < -64'sd2147483648) a = -64'sd2147483648;
        if (a > 64'sd2147483648) a = 64'sd2147483648;
        a += 64'sd2147483648;
        s = (a + (64'sd1 << 15)) >> 16;
        r = floor_sqrt(sq);
        p = vector_turns(yl * 32768, r);
        if (p < 0) p = 0;
        if (p > 64'sd2147483648) p = 64'sd2147483648;
        t = (p + (64'sd1 << 14)) >> 15;
    endfunction

    function void note_triangle(logic signed [15:0] v[9]);
        longint s[3], t[3];
        uv_result_t e;
        for (int k = 0; k < 3; k++)
        begin
            vertex_uv(v[3*k], v[3*k+1], v[3*k+2], s[k], t[k]);
        end
        if (s[1] == 65536) s[1] = 0;
        if (s[1] + 32768 <= s[0]) s[1] += 65536;
        if (s[2] + 32768 <= s[0]) s[2] += 65536;
        if (s[2] == 65536)
        begin
            if (s[0] < 32768) s[0] += 65536;
            if (s[1] < 32768) s[1] += 65536;
        end
        e.s0 = s[0][16:0]; e.s1 = s[1][16:0]; e.s2 = s[2][16:0];
        e.t0 = t[0][16:0]; e.t1 = t[1][16:0]; e.t2 = t[2][16:0];
        pending.insert(pending.size(), e);
    endfunction

    function void check_uv(uv_result_t got);
        uv_result_t e;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result s0=%0d t0=%0d", got.s0, got.t0);
            return;
        end
        e = pending.pop_front();
        if (e !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp s=%0d %0d %0d t=%0d %0d %0d got s=%0d %0d %0d t=%0d %0d %0d",
                         e.s0, e.s1, e.s2, e.t0, e.t1, e.t2,
                         got.s0, got.s1, got.s2, got.t0, got.t1, got.t2);
        end
    endfunction
endclass

module testbench;
    import stuv_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [COORD_W-1:0] vin[9] = '{default: '0};
    logic out_valid;
    logic out_stall = 0;
    logic [OUT_W-1:0] s0, s1, s2, t0, t1, t2;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycles = 0;
    uv_scoreboard board = new();

    initial
    begin
        forever #1 clk = ~clk;
    end

    sphere_triangle_uv_mapper_core u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .v0_x(vin[0]), .v0_y(vin[1]), .v0_z(vin[2]),
        .v1_x(vin[3]), .v1_y(vin[4]), .v1_z(vin[5]),
        .v2_x(vin[6]), .v2_y(vin[7]), .v2_z(vin[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .s0(s0), .s1(s1), .s2(s2), .t0(t0), .t1(t1), .t2(t2)
    );

    // receiver: check on transfer, choose the next stall
    always @(posedge clk)
    begin
        uv_result_t r;
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            r.s0 = s0; r.s1 = s1; r.s2 = s2; r.t0 = t0; r.t1 = t1; r.t2 = t2;
            board.check_uv(r);
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // valid stays high from one transfer to the next unless the sender idles
    task automatic send_triangle(logic signed [15:0] v[9]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            vin[i] <= v[i];
        end
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_triangle(v);
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // random triangle from independently picked coordinates, with the axis values +-16384 and 0 mixed in
    task automatic random_triangle();
        logic signed [15:0] v[9];
        for (int i = 0; i < 9; i++)
        begin
            v[i] = pick_coord();
        end
        send_triangle(v);
    endtask

    initial
    begin
        logic signed [15:0] v[9];
        logic signed [15:0] ax[6][3];
        ax = '{'{16384, 0, 0}, '{-16384, 0, 0}, '{0, 16384, 0},
               '{0, -16384, 0}, '{0, 0, 16384}, '{0, 0, -16384}};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // axis vertices, the seam at x=0 z<0, poles, zero vector, extremes
        for (int a = 0; a < 6; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    v[c] = ax[a][c];
                    v[3+c] = ax[(a+b+1)%6][c];
                    v[6+c] = ax[(a+2*b+2)%6][c];
                end
                send_triangle(v);
            end
        end
        for (int i = 0; i < 9; i++) v[i] = 16'sh0000;
        send_triangle(v);
        for (int i = 0; i < 9; i++) v[i] = 16'sh7FFF;
        send_triangle(v);
        for (int i = 0; i < 9; i++) v[i] = 16'sh8000;
        send_triangle(v);
        for (int i = 0; i < 9; i++) v[i] = 16'shFFFF;
        send_triangle(v);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 11 : 65) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 11 : 65) : 0;
            repeat (120) random_triangle();
        end
        in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/stuv_pkg.sv
hw/rtl/stuv_cordic.sv
hw/rtl/stuv_isqrt.sv
hw/rtl/stuv_vertex.sv
hw/rtl/sphere_triangle_uv_mapper_core.sv
test/testbench.sv
